// File: hdl/heartbeat_failover_controller_core_defines.svh
`ifndef HEARTBEAT_FAILOVER_CONTROLLER_CORE_DEFINES_SVH
`define HEARTBEAT_FAILOVER_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hfc check failed");

// next-cycle implication, sampled on clk, off during reset
`define HFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hfc check failed");

`endif

// File: hdl/hfc_pkg.sv
package hfc_pkg;

    typedef enum logic [1:0] {
        ROLE_IDLE    = 2'd0,
        ROLE_STANDBY = 2'd1,
        ROLE_MASTER  = 2'd2
    } role_t;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_LOST  = 2'd1,
        OP_TICK  = 2'd2,
        OP_FORCE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        FS_NONE   = 2'd0,
        FS_ACCEPT = 2'd1,
        FS_REJECT = 2'd2
    } frame_status_t;

    typedef enum logic [2:0] {
        CFG_START_BYTE    = 3'd0,
        CFG_FUNCTION_BYTE = 3'd1,
        CFG_END_BYTE      = 3'd2,
        CFG_LOCAL_PRIO    = 3'd3,
        CFG_MISSED_LIMIT  = 3'd4,
        CFG_STARTUP_DELAY = 3'd5
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 16;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 16;

    localparam logic [15:0] LEN_SHORT     = 16'd8;
    localparam logic [15:0] LEN_LONG      = 16'd11;
    localparam logic [3:0]  POS_LEN_HIGH  = 4'd3;
    localparam logic [3:0]  POS_ROLE      = 4'd4;
    localparam logic [3:0]  POS_PRIO_LOW  = 4'd13;
    localparam logic [3:0]  POS_PRIO_HIGH = 4'd14;
    localparam logic [3:0]  POS_LAST_SHORT = 4'd13;
    localparam logic [3:0]  POS_LAST_LONG  = 4'd15;
    localparam logic [7:0]  MISSED_MAX    = 8'd255;
    localparam logic [7:0]  MISSED_LIMIT_RESET = 8'd3;

endpackage

// File: hdl/heartbeat_failover_controller_core.sv
// Heartbeat failover controller. One word per cycle is taken on s_axis when m_axis is not
// stalled (tuser selects heartbeat byte, peer lost, time tick or forced role) and exactly
// one result word per input word comes out on m_axis from the result register.
// Sustained rate is one word per cycle: every word goes through an input register and then
// a combinational update of the role/peer state into the result register; downstream
// stalls back up through those two registers. Configuration is taken on cfg_* at any
// time (cfg_ready is always high) but must only be written while the stream is idle;
// writing the startup delay also reloads the startup countdown.
module heartbeat_failover_controller_core
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] rx_byte, [9:8] requested_role, [15:10] zero
    input  logic [hfc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] op
    input  logic [hfc_pkg::IN_USER_W-1:0]     s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] role_now, [2] role_changed, [3] alive_flag, [5:4] frame_status,
    // [13:6] missed_now, [15:14] zero
    output logic [hfc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration
    logic [7:0]  start_byte_reg;
    logic [7:0]  function_byte_reg;
    logic [7:0]  end_byte_reg;
    logic [15:0] local_prio_reg;
    logic [7:0]  missed_limit_reg;

    // input stage
    logic               in_valid_reg;
    hfc_pkg::op_t       in_op_reg;
    logic [7:0]         in_byte_reg;
    logic [1:0]         in_req_reg;

    // controller state
    hfc_pkg::role_t     role_reg,         role_next;
    logic [7:0]         peer_role_reg,    peer_role_next;
    logic [15:0]        peer_prio_reg,    peer_prio_next;
    logic               peer_alive_reg,   peer_alive_next;
    logic [7:0]         missed_reg,       missed_next;
    logic [15:0]        startup_left_reg, startup_left_next;
    logic [3:0]         byte_pos_reg,     byte_pos_next;
    logic               long_frame_reg,   long_frame_next;
    logic [7:0]         held_role_reg,    held_role_next;
    logic [15:0]        held_prio_reg,    held_prio_next;
    logic [7:0]         hdr_reg [0:2];

    // result stage
    logic                      out_valid_reg;
    logic [hfc_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic s_accept;
    logic advance;
    logic work;
    logic cfg_write;
    logic hdr_write;
    hfc_pkg::frame_status_t status;
    logic run_check;
    logic last_byte;
    logic [15:0] frame_len;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign work          = in_valid_reg && advance;
    assign cfg_ready     = 1'b1;
    assign cfg_write     = cfg_valid && cfg_ready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign hdr_write = work && (in_op_reg == hfc_pkg::OP_BYTE)
                       && (byte_pos_reg < hfc_pkg::POS_LEN_HIGH);
    assign frame_len = {in_byte_reg, hdr_reg[2]};
    assign last_byte = long_frame_reg ? (byte_pos_reg == hfc_pkg::POS_LAST_LONG)
                                      : (byte_pos_reg >= hfc_pkg::POS_LAST_SHORT);

    always_comb
    begin
        role_next         = role_reg;
        peer_role_next    = peer_role_reg;
        peer_prio_next    = peer_prio_reg;
        peer_alive_next   = peer_alive_reg;
        missed_next       = missed_reg;
        startup_left_next = startup_left_reg;
        byte_pos_next     = byte_pos_reg;
        long_frame_next   = long_frame_reg;
        held_role_next    = held_role_reg;
        held_prio_next    = held_prio_reg;
        status            = hfc_pkg::FS_NONE;
        run_check         = 1'b0;

        unique case (in_op_reg)
            hfc_pkg::OP_BYTE:
            begin
                if (byte_pos_reg < hfc_pkg::POS_LEN_HIGH)
                begin
                    byte_pos_next = byte_pos_reg + 4'd1;
                end
                else if (byte_pos_reg == hfc_pkg::POS_LEN_HIGH)
                begin
                    if (frame_len == hfc_pkg::LEN_SHORT || frame_len == hfc_pkg::LEN_LONG)
                    begin
                        long_frame_next = (frame_len == hfc_pkg::LEN_LONG);
                        held_role_next  = 8'd0;
                        held_prio_next  = 16'd0;
                        byte_pos_next   = hfc_pkg::POS_ROLE;
                    end
                    else
                    begin
                        byte_pos_next = 4'd0;
                        status        = hfc_pkg::FS_REJECT;
                    end
                end
                else
                begin
                    if (byte_pos_reg == hfc_pkg::POS_ROLE)
                    begin
                        held_role_next = in_byte_reg;
                    end
                    if (long_frame_reg && byte_pos_reg == hfc_pkg::POS_PRIO_LOW)
                    begin
                        held_prio_next[7:0] = in_byte_reg;
                    end
                    if (long_frame_reg && byte_pos_reg == hfc_pkg::POS_PRIO_HIGH)
                    begin
                        held_prio_next[15:8] = in_byte_reg;
                    end
                    if (!last_byte)
                    begin
                        byte_pos_next = byte_pos_reg + 4'd1;
                    end
                    else
                    begin
                        byte_pos_next = 4'd0;
                        if (hdr_reg[0] == start_byte_reg && hdr_reg[1] == function_byte_reg
                            && in_byte_reg == end_byte_reg)
                        begin
                            status          = hfc_pkg::FS_ACCEPT;
                            missed_next     = 8'd0;
                            peer_role_next  = held_role_reg;
                            peer_prio_next  = long_frame_reg ? held_prio_reg : 16'd0;
                            peer_alive_next = 1'b1;
                            run_check       = 1'b1;
                        end
                        else
                        begin
                            status = hfc_pkg::FS_REJECT;
                        end
                    end
                end
            end
            hfc_pkg::OP_LOST:
            begin
                peer_alive_next = 1'b0;
                run_check       = 1'b1;
            end
            hfc_pkg::OP_TICK:
            begin
                if (startup_left_reg != 16'd0)
                begin
                    startup_left_next = startup_left_reg - 16'd1;
                end
            end
            hfc_pkg::OP_FORCE:
            begin
                if (in_req_reg <= hfc_pkg::ROLE_MASTER)
                begin
                    role_next = hfc_pkg::role_t'(in_req_reg);
                end
            end
        endcase

        if (run_check && startup_left_reg == 16'd0)
        begin
            if (!peer_alive_next && missed_next != hfc_pkg::MISSED_MAX)
            begin
                missed_next = missed_next + 8'd1;
            end
            if (!peer_alive_next)
            begin
                if (missed_next >= missed_limit_reg && role_reg != hfc_pkg::ROLE_MASTER)
                begin
                    role_next = hfc_pkg::ROLE_MASTER;
                end
            end
            else if (role_reg == hfc_pkg::ROLE_IDLE)
            begin
                if (peer_role_next != {6'd0, hfc_pkg::ROLE_MASTER}
                    && local_prio_reg > peer_prio_next)
                begin
                    role_next = hfc_pkg::ROLE_MASTER;
                end
                else
                begin
                    role_next = hfc_pkg::ROLE_STANDBY;
                end
            end
            else if (role_reg == hfc_pkg::ROLE_MASTER
                     && peer_role_next == {6'd0, hfc_pkg::ROLE_MASTER}
                     && local_prio_reg < peer_prio_next)
            begin
                role_next = hfc_pkg::ROLE_STANDBY;
            end
        end

        out_data_next = {2'b00, missed_next, status, peer_alive_next,
                         (role_next != role_reg), role_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg    <= 8'd0;
            function_byte_reg <= 8'd0;
            end_byte_reg      <= 8'd0;
            local_prio_reg    <= 16'd0;
            missed_limit_reg  <= hfc_pkg::MISSED_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hfc_pkg::CFG_START_BYTE:    start_byte_reg    <= cfg_data[7:0];
                hfc_pkg::CFG_FUNCTION_BYTE: function_byte_reg <= cfg_data[7:0];
                hfc_pkg::CFG_END_BYTE:      end_byte_reg      <= cfg_data[7:0];
                hfc_pkg::CFG_LOCAL_PRIO:    local_prio_reg    <= cfg_data;
                hfc_pkg::CFG_MISSED_LIMIT:  missed_limit_reg  <= cfg_data[7:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_op_reg   <= hfc_pkg::OP_BYTE;
            in_byte_reg <= 8'd0;
            in_req_reg  <= 2'd0;
        end
        else if (s_accept)
        begin
            in_op_reg   <= hfc_pkg::op_t'(s_axis_tuser);
            in_byte_reg <= s_axis_tdata[7:0];
            in_req_reg  <= s_axis_tdata[9:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_write)
        begin
            hdr_reg[byte_pos_reg[1:0]] <= in_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg       <= hfc_pkg::ROLE_IDLE;
            peer_role_reg  <= 8'd0;
            peer_prio_reg  <= 16'd0;
            peer_alive_reg <= 1'b0;
            missed_reg     <= 8'd0;
            byte_pos_reg   <= 4'd0;
            long_frame_reg <= 1'b0;
            held_role_reg  <= 8'd0;
            held_prio_reg  <= 16'd0;
        end
        else if (work)
        begin
            role_reg       <= role_next;
            peer_role_reg  <= peer_role_next;
            peer_prio_reg  <= peer_prio_next;
            peer_alive_reg <= peer_alive_next;
            missed_reg     <= missed_next;
            byte_pos_reg   <= byte_pos_next;
            long_frame_reg <= long_frame_next;
            held_role_reg  <= held_role_next;
            held_prio_reg  <= held_prio_next;
        end
    end

    // delay reload on config write; ticks count down otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startup_left_reg <= 16'd0;
        end
        else if (cfg_write && cfg_index == hfc_pkg::CFG_STARTUP_DELAY)
        begin
            startup_left_reg <= cfg_data;
        end
        else if (work)
        begin
            startup_left_reg <= startup_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: hdl/hfc_checker.sv
`include "heartbeat_failover_controller_core_defines.svh"

module hfc_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [hfc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [1:0] role_now;
    logic       alive_flag;
    logic [1:0] frame_status;
    logic [7:0] missed_now;

    assign role_now     = m_axis_tdata[1:0];
    assign alive_flag   = m_axis_tdata[3];
    assign frame_status = m_axis_tdata[5:4];
    assign missed_now   = m_axis_tdata[13:6];

    // stalled result word holds
    `HFC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))
    // accepted frame leaves peer alive with a cleared count
    `HFC_ASSERT_NOW(a_accept_alive, m_axis_tvalid && frame_status == hfc_pkg::FS_ACCEPT,
                    alive_flag && missed_now == 8'd0)
    // missed count only grows while the peer is dead
    `HFC_ASSERT_NOW(a_missed_dead, m_axis_tvalid && missed_now != 8'd0, !alive_flag)
    // role code and frame status are always defined codes
    `HFC_ASSERT_NOW(a_role_code, m_axis_tvalid,
                    role_now != 2'd3 && frame_status != 2'd3)

endmodule

bind heartbeat_failover_controller_core hfc_checker u_hfc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/heartbeat_failover_controller_core_test.sv
module heartbeat_failover_controller_core_test;

    localparam int CYCLE_LIMIT = 300000;
    localparam int REPORT_CAP  = 200;

    typedef struct packed {
        hfc_pkg::role_t         role;
        logic                   chg;
        logic                   alive;
        hfc_pkg::frame_status_t status;
        logic [7:0]             missed;
    } hb_result_t;

    typedef struct packed {
        hfc_pkg::op_t op;
        logic [7:0]   rx;
        logic [1:0]   req;
        logic         typed;
        hb_result_t   want;
    } hb_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [hfc_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [hfc_pkg::IN_USER_W-1:0]   s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [hfc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [hfc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [hfc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // word in flight on s_axis, carries its typed expectation if any
    hb_word_t   drv_word;

    // controller image
    logic [7:0]     start_b = 8'd0;
    logic [7:0]     fun_b = 8'd0;
    logic [7:0]     end_b = 8'd0;
    logic [15:0]    local_prio = 16'd0;
    logic [7:0]     miss_limit = hfc_pkg::MISSED_LIMIT_RESET;
    hfc_pkg::role_t cur_role = hfc_pkg::ROLE_IDLE;
    logic [7:0]     peer_role_q = 8'd0;
    logic [15:0]    peer_prio = 16'd0;
    logic           peer_up = 1'b0;
    logic [7:0]     missed_cnt = 8'd0;
    logic [15:0]    boot_left = 16'd0;
    logic [3:0]     byte_pos = 4'd0;
    logic [7:0]     hdr [4];
    logic           long_frm = 1'b0;
    logic [7:0]     held_role = 8'd0;
    logic [15:0]    held_prio = 16'd0;

    hb_result_t expected_q [$];
    hb_word_t   plan_q [$];

    bit steady = 1'b0;
    int mismatches = 0;
    int cycles = 0;
    int words_sent = 0;
    int n_accept = 0;
    int n_reject = 0;
    int n_role_chg = 0;
    int n_phases = 0;

    heartbeat_failover_controller_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void failover_update();
        if (boot_left != 16'd0)
            return;
        if (!peer_up && missed_cnt != hfc_pkg::MISSED_MAX)
            missed_cnt++;
        if (!peer_up)
        begin
            if (missed_cnt >= miss_limit && cur_role != hfc_pkg::ROLE_MASTER)
                cur_role = hfc_pkg::ROLE_MASTER;
        end
        else if (cur_role == hfc_pkg::ROLE_IDLE)
        begin
            if (peer_role_q == 8'(hfc_pkg::ROLE_MASTER) || local_prio <= peer_prio)
                cur_role = hfc_pkg::ROLE_STANDBY;
            else
                cur_role = hfc_pkg::ROLE_MASTER;
        end
        else if (cur_role == hfc_pkg::ROLE_MASTER && peer_role_q == 8'(hfc_pkg::ROLE_MASTER)
                 && local_prio < peer_prio)
            cur_role = hfc_pkg::ROLE_STANDBY;
    endfunction

    function automatic hfc_pkg::frame_status_t frame_byte(logic [7:0] b);
        logic [15:0] len;
        logic [3:0]  last;
        if (byte_pos < hfc_pkg::POS_ROLE)
        begin
            hdr[byte_pos[1:0]] = b;
            if (byte_pos < hfc_pkg::POS_LEN_HIGH)
            begin
                byte_pos++;
                return hfc_pkg::FS_NONE;
            end
            len = {hdr[3], hdr[2]};
            if (len == hfc_pkg::LEN_SHORT)
                long_frm = 1'b0;
            else if (len == hfc_pkg::LEN_LONG)
                long_frm = 1'b1;
            else
            begin
                byte_pos = 4'd0;
                return hfc_pkg::FS_REJECT;
            end
            held_role = 8'd0;
            held_prio = 16'd0;
            byte_pos = hfc_pkg::POS_ROLE;
            return hfc_pkg::FS_NONE;
        end
        last = long_frm ? hfc_pkg::POS_LAST_LONG : hfc_pkg::POS_LAST_SHORT;
        if (byte_pos == hfc_pkg::POS_ROLE)
            held_role = b;
        if (long_frm && byte_pos == hfc_pkg::POS_PRIO_LOW)
            held_prio[7:0] = b;
        if (long_frm && byte_pos == hfc_pkg::POS_PRIO_HIGH)
            held_prio[15:8] = b;
        if (byte_pos != last)
        begin
            byte_pos++;
            return hfc_pkg::FS_NONE;
        end
        byte_pos = 4'd0;
        if (hdr[0] != start_b || hdr[1] != fun_b || b != end_b)
            return hfc_pkg::FS_REJECT;
        missed_cnt = 8'd0;
        peer_role_q = held_role;
        peer_prio = long_frm ? held_prio : 16'd0;
        peer_up = 1'b1;
        failover_update();
        return hfc_pkg::FS_ACCEPT;
    endfunction

    function automatic hb_result_t step_controller(hfc_pkg::op_t op, logic [7:0] rx,
                                                   logic [1:0] req);
        hb_result_t     r;
        hfc_pkg::role_t was;
        was = cur_role;
        r.status = hfc_pkg::FS_NONE;
        case (op)
            hfc_pkg::OP_BYTE:  r.status = frame_byte(rx);
            hfc_pkg::OP_LOST:
            begin
                peer_up = 1'b0;
                failover_update();
            end
            hfc_pkg::OP_TICK:  if (boot_left != 16'd0) boot_left--;
            default:  if (req <= hfc_pkg::ROLE_MASTER) cur_role = hfc_pkg::role_t'(req);
        endcase
        r.role = cur_role;
        r.chg = (cur_role != was);
        r.alive = peer_up;
        r.missed = missed_cnt;
        return r;
    endfunction

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        hb_result_t want;
        hb_result_t pred;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word expected none got %h", $time, m_axis_tdata);
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("role_now", 16'(want.role), 16'(m_axis_tdata[1:0]));
                check_field("role_changed", 16'(want.chg), 16'(m_axis_tdata[2]));
                check_field("alive_flag", 16'(want.alive), 16'(m_axis_tdata[3]));
                check_field("frame_status", 16'(want.status), 16'(m_axis_tdata[5:4]));
                check_field("missed_now", 16'(want.missed), 16'(m_axis_tdata[13:6]));
                n_accept += (want.status == hfc_pkg::FS_ACCEPT);
                n_reject += (want.status == hfc_pkg::FS_REJECT);
                n_role_chg += want.chg;
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            pred = step_controller(hfc_pkg::op_t'(s_axis_tuser), s_axis_tdata[7:0],
                                   s_axis_tdata[9:8]);
            expected_q.insert(expected_q.size(), drv_word.typed ? drv_word.want : pred);
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (hfc_pkg::cfg_index_t'(cfg_index))
                hfc_pkg::CFG_START_BYTE:    start_b = cfg_data[7:0];
                hfc_pkg::CFG_FUNCTION_BYTE: fun_b = cfg_data[7:0];
                hfc_pkg::CFG_END_BYTE:      end_b = cfg_data[7:0];
                hfc_pkg::CFG_LOCAL_PRIO:    local_prio = cfg_data;
                hfc_pkg::CFG_MISSED_LIMIT:  miss_limit = cfg_data[7:0];
                hfc_pkg::CFG_STARTUP_DELAY: boot_left = cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 29);

    function automatic void add_word(hb_word_t w);
        plan_q.insert(plan_q.size(), w);
    endfunction

    function automatic hb_word_t plain(hfc_pkg::op_t op, logic [7:0] rx, logic [1:0] req);
        hb_word_t w;
        w = '0;
        w.op = op;
        w.rx = rx;
        w.req = req;
        return w;
    endfunction

    function automatic hb_word_t row(hfc_pkg::op_t op, logic [7:0] rx, logic [1:0] req,
                                     hfc_pkg::role_t role, logic chg, logic alive,
                                     hfc_pkg::frame_status_t st, logic [7:0] missed);
        hb_word_t w;
        w = plain(op, rx, req);
        w.typed = 1'b1;
        w.want = '{role, chg, alive, st, missed};
        return w;
    endfunction

    function automatic logic [7:0] near(logic [7:0] v);
        return ($urandom_range(9) != 0) ? v : 8'($urandom);
    endfunction

    function automatic void push_event();
        case ($urandom_range(2))
            0:       add_word(plain(hfc_pkg::OP_LOST, 8'($urandom), 2'($urandom)));
            1:       add_word(plain(hfc_pkg::OP_TICK, 8'($urandom), 2'($urandom)));
            default: add_word(plain(hfc_pkg::OP_FORCE, 8'($urandom), 2'($urandom)));
        endcase
    endfunction

    function automatic void push_frame();
        logic        long_f;
        logic [15:0] len;
        logic [15:0] prio;
        logic [7:0]  b;
        int          last;
        long_f = 1'($urandom_range(1));
        len = long_f ? hfc_pkg::LEN_LONG : hfc_pkg::LEN_SHORT;
        if ($urandom_range(99) < 5)
            len = 16'($urandom);
        case ($urandom_range(4))
            0:       prio = 16'h0000;
            1:       prio = 16'hFFFF;
            2:       prio = local_prio;
            3:       prio = local_prio + 16'd1;
            default: prio = 16'($urandom);
        endcase
        last = long_f ? hfc_pkg::POS_LAST_LONG : hfc_pkg::POS_LAST_SHORT;
        for (int p = 0; p <= last; p++)
        begin
            if (p == 0)
                b = near(start_b);
            else if (p == 1)
                b = near(fun_b);
            else if (p == 2)
                b = len[7:0];
            else if (p == hfc_pkg::POS_LEN_HIGH)
                b = len[15:8];
            else if (p == hfc_pkg::POS_ROLE)
                b = ($urandom_range(9) < 8) ? 8'($urandom_range(3)) : 8'($urandom);
            else if (p == last)
                b = near(end_b);
            else if (long_f && p == hfc_pkg::POS_PRIO_LOW)
                b = prio[7:0];
            else if (long_f && p == hfc_pkg::POS_PRIO_HIGH)
                b = prio[15:8];
            else
                b = 8'($urandom);
            add_word(plain(hfc_pkg::OP_BYTE, b, 2'($urandom)));
            if ($urandom_range(99) < 8)
                push_event();
        end
    endfunction

    // mostly well-formed frames, mixed at random with events and broken byte runs
    function automatic void plan_mix(int n);
        int pick;
        while (plan_q.size() < n)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                push_frame();
            else if (pick < 88)
                push_event();
            else
                repeat ($urandom_range(1, 5))
                    add_word(plain(hfc_pkg::OP_BYTE, 8'($urandom), 2'($urandom)));
        end
    endfunction

    task automatic send_word(input hb_word_t w);
        while (!steady && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, w.req, w.rx};
        s_axis_tuser <= w.op;
        drv_word <= w;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_plan();
        while (plan_q.size() != 0)
            send_word(plan_q.pop_front());
        drain_results();
    endtask

    task automatic write_reg(input hfc_pkg::cfg_index_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_config(input logic [7:0] sb, input logic [7:0] fb, input logic [7:0] eb,
                              input logic [15:0] lp, input logic [7:0] lim,
                              input logic [15:0] dly);
        write_reg(hfc_pkg::CFG_START_BYTE, 16'(sb));
        write_reg(hfc_pkg::CFG_FUNCTION_BYTE, 16'(fb));
        write_reg(hfc_pkg::CFG_END_BYTE, 16'(eb));
        write_reg(hfc_pkg::CFG_LOCAL_PRIO, lp);
        write_reg(hfc_pkg::CFG_MISSED_LIMIT, 16'(lim));
        write_reg(hfc_pkg::CFG_STARTUP_DELAY, dly);
        cfg_valid <= 1'b0;
        n_phases++;
    endtask

    initial
    begin
        drv_word = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: all match bytes zero, limit 3, no startup delay
        add_word(row(hfc_pkg::OP_TICK, 8'h00, 2'd0, hfc_pkg::ROLE_IDLE, 1'b0, 1'b0,
                     hfc_pkg::FS_NONE, 8'd0));
        add_word(row(hfc_pkg::OP_FORCE, 8'h00, 2'd3, hfc_pkg::ROLE_IDLE, 1'b0, 1'b0,
                     hfc_pkg::FS_NONE, 8'd0));
        add_word(row(hfc_pkg::OP_LOST, 8'h00, 2'd0, hfc_pkg::ROLE_IDLE, 1'b0, 1'b0,
                     hfc_pkg::FS_NONE, 8'd1));
        add_word(row(hfc_pkg::OP_LOST, 8'h00, 2'd0, hfc_pkg::ROLE_IDLE, 1'b0, 1'b0,
                     hfc_pkg::FS_NONE, 8'd2));
        add_word(row(hfc_pkg::OP_LOST, 8'h00, 2'd0, hfc_pkg::ROLE_MASTER, 1'b1, 1'b0,
                     hfc_pkg::FS_NONE, 8'd3));
        add_word(row(hfc_pkg::OP_FORCE, 8'h00, 2'd1, hfc_pkg::ROLE_STANDBY, 1'b1, 1'b0,
                     hfc_pkg::FS_NONE, 8'd3));
        // header with bad length
        add_word(plain(hfc_pkg::OP_BYTE, 8'h00, 2'd0));
        add_word(plain(hfc_pkg::OP_BYTE, 8'h00, 2'd0));
        add_word(plain(hfc_pkg::OP_BYTE, 8'hFF, 2'd0));
        add_word(row(hfc_pkg::OP_BYTE, 8'hFF, 2'd0, hfc_pkg::ROLE_STANDBY, 1'b0, 1'b0,
                     hfc_pkg::FS_REJECT, 8'd3));
        // short frame from a master peer, a tick in the middle of the header
        add_word(plain(hfc_pkg::OP_BYTE, 8'h00, 2'd0));
        add_word(plain(hfc_pkg::OP_BYTE, 8'h00, 2'd0));
        add_word(plain(hfc_pkg::OP_BYTE, 8'(hfc_pkg::LEN_SHORT), 2'd0));
        add_word(plain(hfc_pkg::OP_TICK, 8'h00, 2'd2));
        add_word(plain(hfc_pkg::OP_BYTE, 8'h00, 2'd0));
        add_word(plain(hfc_pkg::OP_BYTE, 8'(hfc_pkg::ROLE_MASTER), 2'd0));
        for (int i = 0; i < 8; i++)
            add_word(plain(hfc_pkg::OP_BYTE, (i % 2) ? 8'hFF : 8'hAA, 2'd3));
        add_word(row(hfc_pkg::OP_BYTE, 8'h00, 2'd0, hfc_pkg::ROLE_STANDBY, 1'b0, 1'b1,
                     hfc_pkg::FS_ACCEPT, 8'd0));
        send_plan();

        set_config(8'hAA, 8'h55, 8'hFF, 16'h8000, 8'd3, 16'd0);
        plan_mix(230);
        send_plan();

        steady = 1'b1;
        set_config(8'hFF, 8'h00, 8'h00, 16'h0000, 8'd0, 16'd5);
        plan_mix(230);
        send_plan();
        steady = 1'b0;

        // saturate the missed count
        set_config(8'h00, 8'hFF, 8'h7E, 16'hFFFF, 8'd255, 16'd0);
        repeat (260)
            add_word(plain(hfc_pkg::OP_LOST, 8'($urandom), 2'($urandom)));
        plan_mix(300);
        send_plan();

        set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                   8'($urandom_range(1, 6)), 16'($urandom_range(0, 12)));
        plan_mix(230);
        send_plan();

        // decisions held off for the whole phase
        set_config(8'h3C, 8'hC3, 8'h5A, 16'h0001, 8'd1, 16'hFFFF);
        plan_mix(80);
        send_plan();

        set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 8'd2, 16'd0);
        plan_mix(230);
        send_plan();

        mismatches += expected_q.size();
        $display("Sent %0d words over %0d register settings: %0d frames accepted, %0d rejected.",
                 words_sent, n_phases, n_accept, n_reject);
        $display("Role changed %0d times; %0d mismatches.", n_role_chg, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/hfc_pkg.sv
hdl/heartbeat_failover_controller_core.sv
hdl/hfc_checker.sv
tb/heartbeat_failover_controller_core_test.sv
